### design/nrmt_pkg.sv
// Shared types and constants for the ReLU neuron trainer.
// Item structs, op codes, register indexes and controller command encoding.
`default_nettype none

package nrmt_pkg;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] result_value;
    logic               saturated;
  } out_item_t;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_FORWARD = 3'd1;
  localparam logic [2:0] OP_TARGET  = 3'd2;
  localparam logic [2:0] OP_HIDDEN  = 3'd3;
  localparam logic [2:0] OP_UPDATE  = 3'd4;

  localparam logic KIND_OUTPUT   = 1'b0;
  localparam logic KIND_GRADIENT = 1'b1;

  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_MOMENTUM      = 1'b1;

  // 0.15 and 0.5 in unsigned Q0.16
  localparam logic [15:0] LEARNING_RATE_RESET = 16'd9830;
  localparam logic [15:0] MOMENTUM_RESET      = 16'd32768;
  localparam int          RATE_FRAC           = 16;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AW,
    MUL_AB,
    MUL_AG,
    MUL_TLO,
    MUL_THI,
    MUL_MD
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_ACC,
    ACT_FWD,
    ACT_HID,
    ACT_TGT,
    ACT_T,
    ACT_SUM_LO,
    ACT_SUM_HI,
    ACT_SUM_MD,
    ACT_WRITE
  } act_t;

  typedef struct packed {
    logic     latch;
    mul_sel_t mul_sel;
    act_t     act;
  } ctrl_t;

endpackage

`default_nettype wire

### design/nrmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nrmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/nrmt_ctrl.sv
// Sequencer for the neuron trainer: steps each accepted item through the datapath.
// Depends on nrmt_pkg for op codes and the command struct.
`default_nettype none

module nrmt_ctrl
  import nrmt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_op,
  input  wire logic       in_last,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  output ctrl_t           cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ACC,
    S_FWD,
    S_HID,
    S_TGT,
    S_UPD_T,
    S_UPD_HI,
    S_UPD_MD,
    S_UPD_SUM,
    S_UPD_WR
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [2:0] op;
  logic       last;
  logic       out_free;
  logic       accept;
  logic       result_load;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign result_load = (cmd.act == ACT_FWD) || (cmd.act == ACT_HID) || (cmd.act == ACT_TGT);

  always_comb begin
    cmd        = '{latch: 1'b0, mul_sel: MUL_NONE, act: ACT_NONE};
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.latch = accept;
        if (accept) begin
          case (in_op)
            OP_LOAD:    state_next = S_LOAD;
            OP_FORWARD: state_next = S_MUL;
            OP_TARGET:  state_next = S_TGT;
            OP_HIDDEN:  state_next = S_MUL;
            OP_UPDATE:  state_next = S_MUL;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.act    = ACT_LOAD;
        state_next = S_IDLE;
      end
      S_MUL: begin
        case (op)
          OP_FORWARD: cmd.mul_sel = MUL_AW;
          OP_HIDDEN:  cmd.mul_sel = MUL_AB;
          default:    cmd.mul_sel = MUL_AG;
        endcase
        state_next = (op == OP_UPDATE) ? S_UPD_T : S_ACC;
      end
      S_ACC: begin
        cmd.act = ACT_ACC;
        if (!last) begin
          state_next = S_IDLE;
        end else if (op == OP_FORWARD) begin
          state_next = S_FWD;
        end else begin
          state_next = S_HID;
        end
      end
      // hold the result states until the output register is free
      S_FWD: begin
        if (out_free) begin
          cmd.act    = ACT_FWD;
          state_next = S_IDLE;
        end
      end
      S_HID: begin
        if (out_free) begin
          cmd.act    = ACT_HID;
          state_next = S_IDLE;
        end
      end
      S_TGT: begin
        if (out_free) begin
          cmd.act    = ACT_TGT;
          state_next = S_IDLE;
        end
      end
      S_UPD_T: begin
        cmd.mul_sel = MUL_TLO;
        cmd.act     = ACT_T;
        state_next  = S_UPD_HI;
      end
      S_UPD_HI: begin
        cmd.mul_sel = MUL_THI;
        cmd.act     = ACT_SUM_LO;
        state_next  = S_UPD_MD;
      end
      S_UPD_MD: begin
        cmd.mul_sel = MUL_MD;
        cmd.act     = ACT_SUM_HI;
        state_next  = S_UPD_SUM;
      end
      S_UPD_SUM: begin
        cmd.act    = ACT_SUM_MD;
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.act    = ACT_WRITE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op        <= OP_LOAD;
      last      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op   <= in_op;
        last <= in_last;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(result_load && out_valid && !out_ready))
    else $error("result loaded over an untaken transfer");

  a_target_path: assert property (@(posedge clk) disable iff (rst)
    (accept && in_op == OP_TARGET) |=> (state == S_TGT))
    else $error("target item did not enter the target step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(result_load))
    else $error("output valid rose without a result step");

endmodule

`default_nettype wire

### design/nrmt_dp.sv
// Datapath of the neuron trainer: weight and delta memories, shared multiplier,
// accumulator, update arithmetic and the output register. Depends on nrmt_pkg, nrmt_ram.
`default_nettype none

module nrmt_dp
  import nrmt_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire in_item_t    in_item,
  input  wire ctrl_t       cmd,
  output out_item_t        out_item
);

  localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  logic [2:0]          op_q;
  logic [AW-1:0]       addr_q;
  logic                ok_q;
  logic signed [31:0]  a_q;
  logic signed [31:0]  b_q;
  logic [15:0]         eta;
  logic [15:0]         alpha;
  logic signed [63:0]  acc;
  logic signed [31:0]  out_val;
  logic signed [31:0]  grad;
  logic signed [63:0]  prod;
  logic signed [63:0]  t;
  logic signed [63:0]  sum;
  logic [MAX_INPUTS-1:0] dvalid;

  logic [31:0]         w_rd;
  logic [31:0]         d_rd;
  logic signed [31:0]  d_eff;
  logic                in_ok;

  logic signed [32:0]  mx;
  logic signed [32:0]  my;
  logic signed [65:0]  mul_full;
  logic signed [63:0]  tsh;

  logic signed [64:0]  acc_sum;
  logic signed [63:0]  acc_sat;

  logic signed [63:0]  q;
  logic                pos;
  logic                q_fits;
  logic signed [31:0]  fwd_r;
  logic                fwd_clip;
  logic                dz;
  logic signed [31:0]  hid_r;
  logic                hid_clip;
  logic signed [32:0]  diff;
  logic signed [31:0]  tgt_r;
  logic                tgt_clip;

  logic signed [63:0]  ds;
  logic signed [31:0]  d_new;
  logic signed [32:0]  w_sum;
  logic signed [31:0]  w_new;

  logic                w_we;
  logic [31:0]         w_wdata;
  logic                d_we;

  assign in_ok = ({26'd0, in_item.index} < 32'(MAX_INPUTS));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= in_item.op;
      addr_q <= AW'(in_item.index);
      ok_q   <= in_ok;
      a_q    <= in_item.value_a;
      b_q    <= in_item.value_b;
    end
  end

  // weight memory: read at the input transfer, written by load or update
  assign w_we    = ok_q && ((cmd.act == ACT_LOAD) || (cmd.act == ACT_WRITE));
  assign w_wdata = (cmd.act == ACT_LOAD) ? a_q : w_new;
  assign d_we    = ok_q && (cmd.act == ACT_WRITE);

  nrmt_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (addr_q),
    .wdata (w_wdata),
    .re    (cmd.latch),
    .raddr (AW'(in_item.index)),
    .rdata (w_rd)
  );

  nrmt_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_delta_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (addr_q),
    .wdata (d_new),
    .re    (cmd.latch),
    .raddr (AW'(in_item.index)),
    .rdata (d_rd)
  );

  // a delta never written reads as zero
  assign d_eff = (ok_q && dvalid[addr_q]) ? d_rd : 32'sd0;

  assign tsh = prod >>> FRAC_BITS;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AW: begin
        mx = {a_q[31], a_q};
        my = {w_rd[31], w_rd};
      end
      MUL_AB: begin
        mx = {a_q[31], a_q};
        my = {b_q[31], b_q};
      end
      MUL_AG: begin
        mx = {a_q[31], a_q};
        my = {grad[31], grad};
      end
      MUL_TLO: begin
        mx = {1'b0, tsh[31:0]};
        my = {17'd0, eta};
      end
      MUL_THI: begin
        mx = {t[63], t[63:32]};
        my = {17'd0, eta};
      end
      MUL_MD: begin
        mx = {17'd0, alpha};
        my = {d_eff[31], d_eff};
      end
      default: begin
        mx = '0;
        my = '0;
      end
    endcase
  end

  assign mul_full = mx * my;

  // saturating accumulate
  assign acc_sum = {acc[63], acc} + {prod[63], prod};
  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_sat = acc_sum[63:0];
    end
  end

  assign q      = acc >>> FRAC_BITS;
  assign q_fits = (&q[63:31]) || !(|q[63:31]);
  assign pos    = !acc[63] && (acc != 64'sd0);
  assign dz     = out_val[31];

  assign fwd_clip = pos && !q_fits;
  assign fwd_r    = !pos ? 32'sd0 : (fwd_clip ? 32'sh7FFF_FFFF : q[31:0]);

  assign hid_clip = !dz && !q_fits;
  assign hid_r    = dz ? 32'sd0 :
                    (!q_fits ? (q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : q[31:0]);

  assign diff     = {a_q[31], a_q} - {out_val[31], out_val};
  assign tgt_clip = !dz && (diff[32] != diff[31]);
  assign tgt_r    = dz ? 32'sd0 :
                    (tgt_clip ? (diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : diff[31:0]);

  // delta and new weight, both clipped to 32 bits
  assign ds = sum >>> RATE_FRAC;
  always_comb begin
    if ((&ds[63:31]) || !(|ds[63:31])) begin
      d_new = ds[31:0];
    end else begin
      d_new = ds[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    w_sum = {w_rd[31], w_rd} + {d_new[31], d_new};
    if (w_sum[32] != w_sum[31]) begin
      w_new = w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      w_new = w_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= mul_full[63:0];
    end
    case (cmd.act)
      ACT_T:      t   <= tsh;
      ACT_SUM_LO: sum <= prod;
      ACT_SUM_HI: sum <= sum + {prod[31:0], 32'd0};
      ACT_SUM_MD: sum <= sum + prod;
      ACT_FWD: begin
        out_item.result_kind  <= KIND_OUTPUT;
        out_item.result_value <= fwd_r;
        out_item.saturated    <= fwd_clip;
      end
      ACT_HID: begin
        out_item.result_kind  <= KIND_GRADIENT;
        out_item.result_value <= hid_r;
        out_item.saturated    <= hid_clip;
      end
      ACT_TGT: begin
        out_item.result_kind  <= KIND_GRADIENT;
        out_item.result_value <= tgt_r;
        out_item.saturated    <= tgt_clip;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      out_val <= '0;
      grad    <= '0;
      dvalid  <= '0;
      eta     <= LEARNING_RATE_RESET;
      alpha   <= MOMENTUM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEARNING_RATE: eta   <= cfg_data;
          CFG_MOMENTUM:      alpha <= cfg_data;
          default: begin
          end
        endcase
      end
      case (cmd.act)
        ACT_ACC: begin
          // forward elements beyond the weight store add nothing
          if (op_q == OP_HIDDEN || ok_q) begin
            acc <= acc_sat;
          end
        end
        ACT_FWD: begin
          acc     <= '0;
          out_val <= fwd_r;
        end
        ACT_HID: begin
          acc  <= '0;
          grad <= hid_r;
        end
        ACT_TGT: begin
          grad <= tgt_r;
        end
        ACT_WRITE: begin
          if (ok_q) begin
            dvalid[addr_q] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/neuron_relu_momentum_trainer.sv
// Top level of the ReLU neuron trainer: controller, datapath and the channel ports.
// Depends on nrmt_pkg, nrmt_ctrl, nrmt_dp (which holds two nrmt_ram instances).
//
// One ReLU neuron in signed fixed point (FRAC_BITS fraction bits) with up to
// MAX_INPUTS incoming weights and their last deltas, trained by SGD with
// momentum. Items are worked one at a time through a single shared 33x33
// multiplier whose product is registered before use, and the weight and delta
// memories are read at the input transfer. Loads write the weight, targets
// form a gradient, forward or hidden elements multiply and accumulate, updates
// write a new delta and weight, and unused op codes are dropped. A result step
// waits while the output register still holds an untaken result. Weights read
// undefined until loaded; deltas read zero after reset through per-entry valid
// bits, so no clearing pass is needed. learning_rate (index 0) and momentum
// (index 1) are unsigned Q0.16, written through the cfg channel; the user must
// write them only while the block is idle, and the block does not enforce this.
`default_nettype none

module neuron_relu_momentum_trainer
  import nrmt_pkg::*;
#(
  parameter int MAX_INPUTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  ctrl_t cmd;

  assign cfg_ready = 1'b1;

  nrmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_last   (in_item.last),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  nrmt_dp #(
    .MAX_INPUTS (MAX_INPUTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### tb/tb_neuron_relu_momentum_trainer.sv
// Testbench for neuron_relu_momentum_trainer: directed table, then random phases.
// Depends on nrmt_pkg and the design top; holds its own Q16.16 neuron predictor.
`timescale 1ns / 1ps

module tb_neuron_relu_momentum_trainer;
  import nrmt_pkg::*;

  localparam int          NUM_CONN       = 64;
  localparam int          FRAC_BITS_TB   = 16;
  localparam int          SETTLE_CYCLES  = 16;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;
  localparam longint      I32_MAX        = 64'sd2147483647;
  localparam longint      I32_MIN        = -64'sd2147483648;
  localparam longint      I64_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint      I64_MIN        = 64'sh8000_0000_0000_0000;

  typedef struct {
    in_item_t  it;
    bit        fixed;
    out_item_t want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_LEARNING_RATE;
  logic [15:0] cfg_data  = '0;

  // predictor state
  logic signed [31:0] weight_mem [NUM_CONN];
  logic signed [31:0] delta_mem  [NUM_CONN];
  longint             acc_sum;
  logic signed [31:0] neuron_out;
  logic signed [31:0] neuron_grad;
  logic [15:0]        eta;
  logic [15:0]        alpha;

  out_item_t  neuron_outputs_q [$];
  bit         typed_flag_q     [$];
  out_item_t  typed_result_q   [$];
  plan_row_t  plan             [$];
  bit         loaded [NUM_CONN];
  bit         feeding = 1'b0;
  bit         calm    = 1'b0;
  int         errors  = 0;
  int         fed     = 0;
  int         n_results = 0;

  neuron_relu_momentum_trainer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  task automatic flag(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // {clipped, value}
  function automatic logic [32:0] clip32(input longint x);
    if (x > I32_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (x < I32_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, x[31:0]};
  endfunction

  function automatic longint sat_add64(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? I64_MIN : I64_MAX;
    return s;
  endfunction

  task automatic neuron_step(input in_item_t it, output bit produced, output out_item_t res);
    longint      va, vb, t, sum, w;
    longint      relu_d;
    logic [32:0] r;
    int          idx;
    va = longint'(it.value_a);
    vb = longint'(it.value_b);
    idx = int'(it.index);
    relu_d = (neuron_out < 0) ? 0 : 1;
    produced = 1'b0;
    res = '0;
    r = '0;
    case (it.op)
      OP_LOAD: weight_mem[idx] = it.value_a;
      OP_FORWARD: begin
        acc_sum = sat_add64(acc_sum, va * longint'(weight_mem[idx]));
        if (it.last) begin
          if (acc_sum <= 0) r = '0;
          else r = clip32(acc_sum >>> FRAC_BITS_TB);
          acc_sum = 0;
          neuron_out = r[31:0];
          produced = 1'b1;
          res.result_kind = KIND_OUTPUT;
        end
      end
      OP_TARGET: begin
        r = clip32((va - longint'(neuron_out)) * relu_d);
        neuron_grad = r[31:0];
        produced = 1'b1;
        res.result_kind = KIND_GRADIENT;
      end
      OP_HIDDEN: begin
        acc_sum = sat_add64(acc_sum, va * vb);
        if (it.last) begin
          r = clip32((acc_sum >>> FRAC_BITS_TB) * relu_d);
          acc_sum = 0;
          neuron_grad = r[31:0];
          produced = 1'b1;
          res.result_kind = KIND_GRADIENT;
        end
      end
      OP_UPDATE: begin
        t = (va * longint'(neuron_grad)) >>> FRAC_BITS_TB;
        sum = t * longint'({48'd0, eta}) + longint'({48'd0, alpha}) * longint'(delta_mem[idx]);
        r = clip32(sum >>> RATE_FRAC);
        delta_mem[idx] = r[31:0];
        w = longint'(weight_mem[idx]) + longint'($signed(r[31:0]));
        r = clip32(w);
        weight_mem[idx] = r[31:0];
      end
      default: ;
    endcase
    if (produced) begin
      res.result_value = r[31:0];
      res.saturated = r[32];
    end
  endtask

  // input transfer: advance the predictor
  always @(posedge clk) begin
    bit        produced, fixed;
    out_item_t res, typed;
    if (!rst && in_valid && in_ready) begin
      fixed = typed_flag_q.pop_front();
      typed = typed_result_q.pop_front();
      neuron_step(in_item, produced, res);
      if (produced) neuron_outputs_q.insert(neuron_outputs_q.size(), fixed ? typed : res);
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LEARNING_RATE) eta = cfg_data;
      else alpha = cfg_data;
    end
  end

  // output transfer: check against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (neuron_outputs_q.size() == 0) begin
        flag($sformatf("unexpected result kind %0b value %h", out_item.result_kind,
                       out_item.result_value));
      end else begin
        want = neuron_outputs_q.pop_front();
        if (out_item.result_kind !== want.result_kind ||
            out_item.result_value !== want.result_value ||
            out_item.saturated !== want.saturated)
          flag($sformatf("result %0d: kind %0b exp %0b, value %h exp %h, sat %0b exp %0b",
                         n_results, out_item.result_kind, want.result_kind,
                         out_item.result_value, want.result_value,
                         out_item.saturated, want.saturated));
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    #(5_000_000);
    $display("tb_neuron_relu_momentum_trainer NOT OK");
    $finish;
  end

  function automatic in_item_t make_item(input logic [2:0] op, input logic [5:0] idx,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input logic last);
    in_item_t it;
    it.op = op;
    it.index = idx;
    it.value_a = a;
    it.value_b = b;
    it.last = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4, 5: return $urandom();
      default: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
  endfunction

  function automatic logic [5:0] rand_idx();
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // hold valid and payload until the transfer; idle gaps come before the item
  task automatic push(input in_item_t it, input bit fixed, input out_item_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      if (feeding) in_valid <= 1'b0;
      feeding = 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (it.op == OP_LOAD) loaded[it.index] = 1'b1;
    typed_flag_q.insert(typed_flag_q.size(), fixed);
    typed_result_q.insert(typed_result_q.size(), want);
    in_valid <= 1'b1;
    in_item <= it;
    feeding = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // weight readers get a load first when their connection is still unwritten
  task automatic emit(input logic [2:0] op, input logic [5:0] idx, input logic [31:0] a,
                      input logic [31:0] b, input logic last);
    if ((op == OP_FORWARD || op == OP_UPDATE) && !loaded[idx]) begin
      push(make_item(OP_LOAD, idx, rand_q(), rand_q(), rand_bit()), 1'b0, '0);
      fed++;
    end
    push(make_item(op, idx, a, b, last), 1'b0, '0);
    if (op < OP_SPARE_FIRST) fed++;
  endtask

  function automatic int run_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
  endfunction

  task automatic random_phase(input int count);
    int stop_at, len, k;
    stop_at = fed + count;
    while (fed < stop_at) begin
      len = run_len();
      case ($urandom_range(0, 99)) inside
        [0:29]:
          for (k = 0; k < len; k++)
            emit(OP_FORWARD, rand_idx(), rand_q(), rand_q(), k == len - 1);
        [30:44]:
          for (k = 0; k < len; k++)
            emit(OP_HIDDEN, rand_idx(), rand_q(), rand_q(), k == len - 1);
        [45:56]:
          emit(OP_TARGET, rand_idx(), rand_q(), rand_q(), rand_bit());
        [57:71]:
          for (k = 0; k < len; k++)
            emit(OP_UPDATE, rand_idx(), rand_q(), rand_q(), rand_bit());
        [72:84]:
          emit(OP_LOAD, rand_idx(), rand_q(), rand_q(), rand_bit());
        default:
          // noise: any op code, any last mark, broken runs included
          for (k = 0; k < len; k++)
            emit(3'($urandom_range(OP_LOAD, OP_SPARE_LAST)), rand_idx(),
                 rand_q(), rand_q(), rand_bit());
      endcase
    end
  endtask

  // drop valid, drain the expectations, then let a trailing update finish
  task automatic settle();
    if (feeding) in_valid <= 1'b0;
    feeding = 1'b0;
    while (neuron_outputs_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rates(input logic [15:0] lr, input logic [15:0] mom);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LEARNING_RATE;
    cfg_data  <= lr;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MOMENTUM;
    cfg_data  <= mom;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_row(input logic [2:0] op, input logic [5:0] idx, input logic [31:0] a,
                          input logic [31:0] b, input logic last, input bit fixed,
                          input logic kind, input logic [31:0] val, input logic sat);
    plan_row_t row;
    row.it = make_item(op, idx, a, b, last);
    row.fixed = fixed;
    row.want.result_kind = kind;
    row.want.result_value = val;
    row.want.saturated = sat;
    plan.insert(plan.size(), row);
  endtask

  initial begin
    int i;
    for (i = 0; i < NUM_CONN; i++) begin
      delta_mem[i] = '0;
      weight_mem[i] = '0;
      loaded[i] = 1'b0;
    end
    acc_sum = 0;
    neuron_out = '0;
    neuron_grad = '0;
    eta = LEARNING_RATE_RESET;
    alpha = MOMENTUM_RESET;

    // gradients straight after reset, output is zero
    plan_row(OP_TARGET, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b1,
             KIND_GRADIENT, 32'h7FFF_FFFF, 1'b0);
    plan_row(OP_TARGET, 6'd63, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
             KIND_GRADIENT, 32'h8000_0000, 1'b0);
    plan_row(OP_HIDDEN, 6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
             KIND_GRADIENT, 32'h7FFF_FFFF, 1'b1);
    plan_row(OP_HIDDEN, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1,
             KIND_GRADIENT, 32'h8000_0000, 1'b1);
    // two full-scale products overflow the 64-bit accumulator
    plan_row(OP_HIDDEN, 6'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_HIDDEN, 6'd0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
             KIND_GRADIENT, 32'h7FFF_FFFF, 1'b1);
    plan_row(OP_HIDDEN, 6'd0, 32'h0, 32'h0, 1'b1, 1'b1, KIND_GRADIENT, 32'h0, 1'b0);
    plan_row(OP_LOAD, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_LOAD, 6'd63, 32'h8000_0000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_LOAD, 6'd1, 32'h0001_0000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_FORWARD, 6'd1, 32'h0003_0000, 32'h0, 1'b1, 1'b1,
             KIND_OUTPUT, 32'h0003_0000, 1'b0);
    // negative sum gives zero without the clip mark
    plan_row(OP_FORWARD, 6'd63, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_FORWARD, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1,
             KIND_OUTPUT, 32'h7FFF_FFFF, 1'b1);
    plan_row(OP_TARGET, 6'd5, 32'h8000_0000, 32'h0, 1'b0, 1'b1,
             KIND_GRADIENT, 32'h8000_0000, 1'b1);
    plan_row(OP_UPDATE, 6'd1, 32'h0001_0000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_UPDATE, 6'd1, 32'hFFFF_0000, 32'h0, 1'b1, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    // reload keeps the old delta for the next update
    plan_row(OP_LOAD, 6'd1, 32'h0002_0000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_UPDATE, 6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_SPARE_FIRST, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_SPARE_FIRST + 3'd1, 6'd21, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_SPARE_LAST, 6'd42, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    // forward and hidden elements share one accumulator
    plan_row(OP_FORWARD, 6'd1, 32'h0001_0000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_HIDDEN, 6'd9, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0,
             KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_FORWARD, 6'd63, 32'h0000_0001, 32'h0, 1'b1, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);
    plan_row(OP_TARGET, 6'd0, 32'h0000_8000, 32'h0, 1'b0, 1'b0, KIND_OUTPUT, 32'h0, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) push(plan[k].it, plan[k].fixed, plan[k].want);
    random_phase(80);
    settle();
    write_rates(16'd0, 16'd0);
    random_phase(90);
    settle();
    write_rates(16'hFFFF, 16'hFFFF);
    random_phase(90);
    settle();
    write_rates(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_phase(90);
    settle();
    write_rates(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_phase(90);
    settle();
    calm = 1'b1;
    write_rates(LEARNING_RATE_RESET, MOMENTUM_RESET);
    random_phase(90);
    settle();

    if (errors == 0)
      $display("tb_neuron_relu_momentum_trainer OK");
    else
      $display("tb_neuron_relu_momentum_trainer NOT OK");
    $finish;
  end

endmodule
